// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/srdd_pkg.sv
// ---------------------------------------------------------------------------
// srdd_pkg
// Types and constants for the scan reply distance decoder.
// ---------------------------------------------------------------------------
package srdd_pkg;

    localparam int BYTE_W  = 8;
    localparam int DIST_W  = 24;
    localparam int SIX_W   = 6;
    localparam int CFG_W   = 3;
    localparam int CNT_W   = 2;
    localparam int LINES_W = 3;

    localparam logic [BYTE_W-1:0]  LINE_FEED   = 8'h0A;
    localparam logic [BYTE_W-1:0]  CHAR_OFFSET = 8'h30;
    localparam logic [LINES_W-1:0] LINES_MAX   = 3'd7;

    localparam logic [CFG_W-1:0] HEADER_LINES_RESET    = 3'd3;
    localparam logic [CFG_W-1:0] CHARS_PER_VALUE_RESET = 3'd3;
    localparam logic [CFG_W-1:0] GROUP_MIN             = 3'd2;
    localparam logic [CFG_W-1:0] GROUP_MAX             = 3'd4;

    typedef enum logic [0:0] {
        REG_HEADER_LINES    = 1'b0,
        REG_CHARS_PER_VALUE = 1'b1
    } reg_index_t;

endpackage

// File: hdl/scan_reply_distance_decoder.sv
// ---------------------------------------------------------------------------
// scan_reply_distance_decoder
// Decodes range scanner reply bytes into six-bit-per-character distances.
// ---------------------------------------------------------------------------
// channel   direction  payload
// s_axis    in         tdata[7:0] rx_byte
// m_axis    out        tdata[23:0] distance_mm, tlast frame_end
// cfg       in         cfg_index register, cfg_data[2:0] value
//
// One byte enters per cycle while the input side is not stalled; each byte is
// held in the input register and its result is then loaded into the result register.
// rst_n clears all decode state and restores header_lines = 3,
// chars_per_value = 3. A stalled output holds its transfer; the input side
// stalls only while the input register is full and the result is not taken.
// ---------------------------------------------------------------------------
module scan_reply_distance_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [23:0] distance_mm
    output logic        m_axis_tlast,   // frame_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [2:0]  cfg_data
);

    logic [srdd_pkg::CFG_W-1:0]   header_lines_reg;
    logic [srdd_pkg::CFG_W-1:0]   chars_per_value_reg;

    logic                          in_valid_reg;
    logic [srdd_pkg::BYTE_W-1:0]   in_byte_reg;

    logic                          in_header_reg,     in_header_next;
    logic [srdd_pkg::LINES_W-1:0]  lines_skipped_reg, lines_skipped_next;
    logic                          held_valid_reg,    held_valid_next;
    logic [srdd_pkg::BYTE_W-1:0]   held_char_reg,     held_char_next;
    logic [srdd_pkg::DIST_W-1:0]   value_acc_reg,     value_acc_next;
    logic [srdd_pkg::CNT_W-1:0]    group_count_reg,   group_count_next;
    logic                          line_empty_reg,    line_empty_next;

    logic                          out_valid_reg;
    logic [srdd_pkg::DIST_W-1:0]   out_data_reg,      out_data_next;
    logic                          out_last_reg,      out_last_next;
    logic                          produce;

    logic                          advance;
    logic [srdd_pkg::CFG_W-1:0]    group_size;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // clamp group size to 2..4
    always_comb
    begin
        priority if (chars_per_value_reg < srdd_pkg::GROUP_MIN)
            group_size = srdd_pkg::GROUP_MIN;
        else if (chars_per_value_reg > srdd_pkg::GROUP_MAX)
            group_size = srdd_pkg::GROUP_MAX;
        else
            group_size = chars_per_value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_lines_reg    <= srdd_pkg::HEADER_LINES_RESET;
            chars_per_value_reg <= srdd_pkg::CHARS_PER_VALUE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (srdd_pkg::reg_index_t'(cfg_index))
                srdd_pkg::REG_HEADER_LINES:    header_lines_reg    <= cfg_data;
                srdd_pkg::REG_CHARS_PER_VALUE: chars_per_value_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic                        header_now;
        logic [srdd_pkg::LINES_W-1:0] lines_inc;
        logic [srdd_pkg::SIX_W-1:0]  six;
        logic [srdd_pkg::CNT_W:0]    cnt_inc;
        logic [srdd_pkg::BYTE_W-1:0] diff;
        logic                        is_lf;

        in_header_next     = in_header_reg;
        lines_skipped_next = lines_skipped_reg;
        held_valid_next    = held_valid_reg;
        held_char_next     = held_char_reg;
        value_acc_next     = value_acc_reg;
        group_count_next   = group_count_reg;
        line_empty_next    = line_empty_reg;
        produce            = 1'b0;
        out_data_next      = '0;
        out_last_next      = 1'b0;

        is_lf      = (in_byte_reg == srdd_pkg::LINE_FEED);
        header_now = in_header_reg && (lines_skipped_reg < header_lines_reg);
        lines_inc  = (lines_skipped_reg < srdd_pkg::LINES_MAX)
                   ? lines_skipped_reg + 1'b1 : lines_skipped_reg;
        diff       = held_char_reg - srdd_pkg::CHAR_OFFSET;
        six        = diff[srdd_pkg::SIX_W-1:0];
        cnt_inc    = {1'b0, group_count_reg} + 1'b1;

        if (header_now)
        begin
            if (is_lf)
            begin
                lines_skipped_next = lines_inc;
                if (lines_inc >= header_lines_reg)
                begin
                    in_header_next  = 1'b0;
                    line_empty_next = 1'b1;
                end
            end
        end
        else
        begin
            in_header_next = 1'b0;
            if (is_lf)
            begin
                if (line_empty_reg)
                begin
                    // empty line: emit end marker and re-arm
                    produce            = 1'b1;
                    out_last_next      = 1'b1;
                    in_header_next     = 1'b1;
                    lines_skipped_next = '0;
                    held_valid_next    = 1'b0;
                    held_char_next     = '0;
                    value_acc_next     = '0;
                    group_count_next   = '0;
                    line_empty_next    = 1'b1;
                end
                else
                begin
                    // drop the held check character
                    held_valid_next = 1'b0;
                    held_char_next  = '0;
                    line_empty_next = 1'b1;
                end
            end
            else
            begin
                if (held_valid_reg)
                begin
                    value_acc_next   = {value_acc_reg[srdd_pkg::DIST_W-srdd_pkg::SIX_W-1:0],
                                        six};
                    group_count_next = cnt_inc[srdd_pkg::CNT_W-1:0];
                    if (cnt_inc >= group_size)
                    begin
                        produce          = 1'b1;
                        out_data_next    = value_acc_next;
                        value_acc_next   = '0;
                        group_count_next = '0;
                    end
                end
                held_char_next  = in_byte_reg;
                held_valid_next = 1'b1;
                line_empty_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            in_header_reg     <= 1'b1;
            lines_skipped_reg <= '0;
            held_valid_reg    <= 1'b0;
            held_char_reg     <= '0;
            value_acc_reg     <= '0;
            group_count_reg   <= '0;
            line_empty_reg    <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
            begin
                in_header_reg     <= in_header_next;
                lines_skipped_reg <= lines_skipped_next;
                held_valid_reg    <= held_valid_next;
                held_char_reg     <= held_char_next;
                value_acc_reg     <= value_acc_next;
                group_count_reg   <= group_count_next;
                line_empty_reg    <= line_empty_next;
            end
            if (advance)
                out_valid_reg <= produce;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
        if (advance && produce)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

endmodule

// File: hdl/srdd_checker.sv
// ---------------------------------------------------------------------------
// srdd_checker
// Port-level checks for the scan reply distance decoder.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module srdd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        cfg_ready
);

    // end marker carries a zero distance
    `ASSERT_IMPLIES(a_end_zero, clk, rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata == 24'd0)
    // a free output never backs up the input
    `ASSERT_IMPLIES(a_no_stall, clk, rst_n, m_axis_tready, s_axis_tready)
    // configuration writes are never refused
    `ASSERT_IMPLIES(a_cfg_open, clk, rst_n, 1'b1, cfg_ready)
    // stalled result holds
    `ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
                 m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind scan_reply_distance_decoder srdd_checker u_srdd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_ready     (cfg_ready)
);
